// ----- hw/rtl/wav_sample_to_pcm16_core_macros.svh -----
// ----------------------------------------------------------------------------
// WAV sample converter assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WAV_SAMPLE_TO_PCM16_CORE_MACROS_SVH
`define WAV_SAMPLE_TO_PCM16_CORE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wav_sample_to_pcm16_core: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wav_sample_to_pcm16_core: next-cycle check failed");
`else
`define WSP_ASSERT_IMP(label, clk, rst, ante, cons)
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// WAV sample converter package
// Format codes, register indexes and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

   localparam logic [2:0] FMT_U8  = 3'd0;
   localparam logic [2:0] FMT_S16 = 3'd1;
   localparam logic [2:0] FMT_S24 = 3'd2;
   localparam logic [2:0] FMT_S32 = 3'd3;
   localparam logic [2:0] FMT_F32 = 3'd4;
   localparam logic [2:0] FMT_F64 = 3'd5;

   localparam logic REG_SAMPLE_FORMAT = 1'b0;
   localparam logic REG_CHANNEL_COUNT = 1'b1;

   localparam logic [2:0] FORMAT_RESET   = FMT_S16;
   localparam logic [1:0] CHANNELS_RESET = 2'd2;
   localparam logic [1:0] STEREO_COUNT   = 2'd2;

   localparam logic [15:0] SAT_POS  = 16'h7fff;
   localparam logic [15:0] SAT_NEG  = 16'h8000;
   localparam logic [7:0]  F32_EXP_MAX = 8'hff;
   localparam logic [10:0] F64_EXP_MAX = 11'h7ff;
   localparam logic [6:0]  F32_BIAS = 7'd127;
   localparam logic [9:0]  F64_BIAS = 10'd1023;

   // one gathered sample waiting for conversion
   typedef struct packed {
      logic [63:0] raw;
      logic [2:0]  fmt;
      logic        channel;
      logic        frame_end;
   } sample_entry_type;

   // after decode: either a finished value or a significand to scale
   typedef struct packed {
      logic        direct;
      logic [15:0] value;
      logic        clip;
      logic        neg;
      logic [52:0] sig;
      logic [3:0]  shift;
      logic        flush;
      logic        channel;
      logic        frame_end;
   } decode_stage_type;

   // after the multiply by 32767: top 16 bits of the product
   typedef struct packed {
      logic        direct;
      logic [15:0] value;
      logic        clip;
      logic        neg;
      logic [15:0] hi;
      logic [3:0]  shift;
      logic        flush;
      logic        channel;
      logic        frame_end;
   } product_stage_type;

   function automatic logic [3:0] bytes_for_format(input logic [2:0] fmt);
      logic [3:0] n;
      case (fmt)
         FMT_U8:  n = 4'd1;
         FMT_S16: n = 4'd2;
         FMT_S24: n = 4'd3;
         FMT_S32: n = 4'd4;
         FMT_F32: n = 4'd4;
         FMT_F64: n = 4'd8;
         default: n = 4'd8;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wsp_gather.sv -----
// ----------------------------------------------------------------------------
// WAV sample gatherer
// Collects little-endian bytes into one sample and tags its channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_gather (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire logic [2:0]                sample_format,
   input  wire logic [1:0]                channel_count,
   input  wire logic                      byte_valid,
   input  wire logic [7:0]                byte_data,
   output      logic                      push,
   output      wsp_pkg::sample_entry_type push_entry
);

   logic [63:0] gather_ff, gather_in;
   logic [2:0]  held_ff, held_in;
   logic        chan_ff, chan_in;
   logic [63:0] merged;
   logic [3:0]  count_next;
   logic        stereo;

   always_comb begin
      stereo     = (channel_count == wsp_pkg::STEREO_COUNT);
      count_next = {1'b0, held_ff} + 4'd1;
      merged     = gather_ff;
      merged[{held_ff, 3'b000} +: 8] = byte_data;

      push_entry.raw       = merged;
      push_entry.fmt       = sample_format;
      push_entry.channel   = stereo & chan_ff;
      push_entry.frame_end = !stereo | chan_ff;

      gather_in = gather_ff;
      held_in   = held_ff;
      chan_in   = chan_ff;
      push      = 1'b0;

      if (clear) begin
         gather_in = '0;
         held_in   = '0;
         chan_in   = 1'b0;
      end else if (byte_valid && sample_format <= wsp_pkg::FMT_F64) begin
         if (count_next >= wsp_pkg::bytes_for_format(sample_format)) begin
            push      = 1'b1;
            gather_in = '0;
            held_in   = '0;
            chan_in   = stereo & ~chan_ff;
         end else begin
            gather_in = merged;
            held_in   = count_next[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gather_ff <= '0;
         held_ff   <= '0;
         chan_ff   <= 1'b0;
      end else begin
         gather_ff <= gather_in;
         held_ff   <= held_in;
         chan_ff   <= chan_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/wsp_queue.sv -----
// ----------------------------------------------------------------------------
// WAV sample queue
// Short first-in first-out buffer between the gatherer and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire wsp_pkg::sample_entry_type push_entry,
   output      logic                      full,
   input  wire logic                      pop,
   output      logic                      head_valid,
   output      wsp_pkg::sample_entry_type head_entry
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   wsp_pkg::sample_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_entry = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/wsp_convert.sv -----
// ----------------------------------------------------------------------------
// WAV sample converter
// Three-stage pipeline: decode, multiply by 32767, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_convert (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire wsp_pkg::sample_entry_type head_entry,
   output      logic                      pop,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic signed [15:0]        rsp_sample_value,
   output      logic                      rsp_channel_index,
   output      logic                      rsp_frame_end,
   output      logic                      rsp_clipped
);

   wsp_pkg::decode_stage_type  dec_in, dec_ff;
   wsp_pkg::product_stage_type prod_in, prod_ff;
   logic        dec_valid_ff, prod_valid_ff, out_valid_ff;
   logic        advance;
   logic [7:0]  e32;
   logic [10:0] e64;
   logic [6:0]  k32;
   logic [9:0]  k64;
   logic [67:0] product;
   logic [15:0] mag;
   logic [15:0] value_in;
   logic        clip_in;
   logic [15:0] value_ff;
   logic        clip_ff, channel_ff, frame_end_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && head_valid;

   // decode: integer formats finish here, floats are classified
   always_comb begin
      e32 = head_entry.raw[30:23];
      e64 = head_entry.raw[62:52];
      k32 = wsp_pkg::F32_BIAS - e32[6:0];
      k64 = wsp_pkg::F64_BIAS - e64[9:0];

      dec_in.direct    = 1'b1;
      dec_in.value     = '0;
      dec_in.clip      = 1'b0;
      dec_in.neg       = 1'b0;
      dec_in.sig       = '0;
      dec_in.shift     = '0;
      dec_in.flush     = 1'b0;
      dec_in.channel   = head_entry.channel;
      dec_in.frame_end = head_entry.frame_end;

      case (head_entry.fmt)
         wsp_pkg::FMT_U8: begin
            dec_in.value = {~head_entry.raw[7], head_entry.raw[6:0], 8'h00};
         end
         wsp_pkg::FMT_S16: dec_in.value = head_entry.raw[15:0];
         wsp_pkg::FMT_S24: dec_in.value = head_entry.raw[23:8];
         wsp_pkg::FMT_S32: dec_in.value = head_entry.raw[31:16];
         wsp_pkg::FMT_F32: begin
            dec_in.neg = head_entry.raw[31];
            if (e32 == wsp_pkg::F32_EXP_MAX && head_entry.raw[22:0] != '0) begin
               dec_in.clip = 1'b1;
            end else if (e32[7]) begin
               // infinity or magnitude of two or more
               dec_in.clip  = 1'b1;
               dec_in.value = head_entry.raw[31] ? wsp_pkg::SAT_NEG : wsp_pkg::SAT_POS;
            end else begin
               dec_in.direct = 1'b0;
               dec_in.sig    = {(e32 != '0), head_entry.raw[22:0], 29'b0};
               dec_in.shift  = k32[3:0];
               dec_in.flush  = |k32[6:4];
            end
         end
         wsp_pkg::FMT_F64: begin
            dec_in.neg = head_entry.raw[63];
            if (e64 == wsp_pkg::F64_EXP_MAX && head_entry.raw[51:0] != '0) begin
               dec_in.clip = 1'b1;
            end else if (e64[10]) begin
               dec_in.clip  = 1'b1;
               dec_in.value = head_entry.raw[63] ? wsp_pkg::SAT_NEG : wsp_pkg::SAT_POS;
            end else begin
               dec_in.direct = 1'b0;
               dec_in.sig    = {(e64 != '0), head_entry.raw[51:0]};
               dec_in.shift  = k64[3:0];
               dec_in.flush  = |k64[9:4];
            end
         end
         default: dec_in.value = '0;
      endcase
   end

   // sig * 32767 as one subtract; only the bits from 2^52 up survive the shift
   always_comb begin
      product = {dec_ff.sig, 15'b0} - {15'b0, dec_ff.sig};

      prod_in.direct    = dec_ff.direct;
      prod_in.value     = dec_ff.value;
      prod_in.clip      = dec_ff.clip;
      prod_in.neg       = dec_ff.neg;
      prod_in.hi        = product[67:52];
      prod_in.shift     = dec_ff.shift;
      prod_in.flush     = dec_ff.flush;
      prod_in.channel   = dec_ff.channel;
      prod_in.frame_end = dec_ff.frame_end;
   end

   // shift down, then sign and saturate
   always_comb begin
      mag      = prod_ff.flush ? '0 : (prod_ff.hi >> prod_ff.shift);
      value_in = prod_ff.value;
      clip_in  = prod_ff.clip;
      if (!prod_ff.direct) begin
         if (!prod_ff.neg) begin
            clip_in  = mag[15];
            value_in = mag[15] ? wsp_pkg::SAT_POS : mag;
         end else if (mag > wsp_pkg::SAT_NEG) begin
            clip_in  = 1'b1;
            value_in = wsp_pkg::SAT_NEG;
         end else begin
            clip_in  = 1'b0;
            value_in = 16'd0 - mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         dec_valid_ff  <= head_valid;
         prod_valid_ff <= dec_valid_ff;
         out_valid_ff  <= prod_valid_ff;
      end
      if (advance) begin
         dec_ff       <= dec_in;
         prod_ff      <= prod_in;
         value_ff     <= value_in;
         clip_ff      <= clip_in;
         channel_ff   <= prod_ff.channel;
         frame_end_ff <= prod_ff.frame_end;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_value  = value_ff;
   assign rsp_clipped       = clip_ff;
   assign rsp_channel_index = channel_ff;
   assign rsp_frame_end     = frame_end_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/wav_sample_to_pcm16_core.sv -----
// A finished sample passes the queue and the decode, product and output registers.
// Throughput: one byte per cycle; one result per 1, 2, 3, 4 or 8 bytes by format.
// The gatherer takes a byte every cycle; input stalls only once the queue fills behind
// a stalled receiver, as the converter takes a sample per cycle.
// Reset: synchronous; format s16, stereo, gatherer and queue emptied, no clearing pass.
// A configuration write restarts gathering at a channel 0 sample.
// ----------------------------------------------------------------------------
// WAV sample to PCM16 core
// Byte gatherer, sample queue and converter behind an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wav_sample_to_pcm16_core_macros.svh"

module wav_sample_to_pcm16_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_data_byte,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [15:0] rsp_sample_value,
   output      logic               rsp_channel_index,
   output      logic               rsp_frame_end,
   output      logic               rsp_clipped,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output      logic [31:0]        prdata,
   output      logic               pready
);

   logic [2:0] sample_format_ff, sample_format_in;
   logic [1:0] channel_count_ff, channel_count_in;
   logic       cfg_write;
   logic       q_full, q_push, q_pop, q_head_valid;
   logic       byte_beat;
   logic       fmt_is_float;
   logic       mono_mode;
   logic       mono_tag;
   logic       clip_nonzero;
   logic       out_saturated;
   wsp_pkg::sample_entry_type push_entry, head_entry;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign req_stall = q_full;
   assign byte_beat = req_valid && !req_stall;

   always_comb begin
      sample_format_in = sample_format_ff;
      channel_count_in = channel_count_ff;
      if (cfg_write) begin
         if (paddr[2] == wsp_pkg::REG_SAMPLE_FORMAT) begin
            sample_format_in = pwdata[2:0];
         end else begin
            channel_count_in = pwdata[1:0];
         end
      end
      if (paddr[2] == wsp_pkg::REG_CHANNEL_COUNT) begin
         prdata = {30'b0, channel_count_ff};
      end else begin
         prdata = {29'b0, sample_format_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= wsp_pkg::FORMAT_RESET;
         channel_count_ff <= wsp_pkg::CHANNELS_RESET;
      end else begin
         sample_format_ff <= sample_format_in;
         channel_count_ff <= channel_count_in;
      end
   end

   wsp_gather u_gather (
      .clock         (clock),
      .reset         (reset),
      .clear         (cfg_write),
      .sample_format (sample_format_ff),
      .channel_count (channel_count_ff),
      .byte_valid    (byte_beat),
      .byte_data     (req_data_byte),
      .push          (q_push),
      .push_entry    (push_entry)
   );

   wsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (head_entry)
   );

   wsp_convert u_convert (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_entry        (head_entry),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_clipped       (rsp_clipped)
   );

   assign fmt_is_float  = (sample_format_ff == wsp_pkg::FMT_F32) ||
                          (sample_format_ff == wsp_pkg::FMT_F64);
   assign mono_mode     = (channel_count_ff != wsp_pkg::STEREO_COUNT);
   assign mono_tag      = !rsp_channel_index && rsp_frame_end;
   assign clip_nonzero  = rsp_clipped && (|rsp_sample_value);
   assign out_saturated = (rsp_sample_value == wsp_pkg::SAT_POS) ||
                          (rsp_sample_value == wsp_pkg::SAT_NEG);

   `WSP_ASSERT_NEXT(a_full_holds, clock, reset, q_full && !q_pop, req_stall)
   `WSP_ASSERT_IMP(a_clip_float_only, clock, reset, rsp_valid && rsp_clipped, fmt_is_float)
   `WSP_ASSERT_IMP(a_mono_tags, clock, reset, rsp_valid && mono_mode, mono_tag)
   `WSP_ASSERT_IMP(a_clip_saturates, clock, reset, rsp_valid && clip_nonzero, out_saturated)

endmodule

`default_nettype wire

// ----- verif/tb_wav_sample_to_pcm16_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV sample to PCM16 core testbench
// Feeds the byte stream with bursty valid and a stalling receiver, predicts
// every PCM sample from its own gatherer and converter, and checks each beat.
// ----------------------------------------------------------------------------
module tb_wav_sample_to_pcm16_core;

   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned RANDOM_BYTES  = 1560;
   localparam int unsigned SETTLE_CYCLES = 8;

   localparam logic [2:0] ADDR_FORMAT   = {wsp_pkg::REG_SAMPLE_FORMAT, 2'b00};
   localparam logic [2:0] ADDR_CHANNELS = {wsp_pkg::REG_CHANNEL_COUNT, 2'b00};

   localparam logic [2:0] FMT_SPARE_LO = 3'd6;
   localparam logic [2:0] FMT_SPARE_HI = 3'd7;
   localparam logic [1:0] CH_ZERO = 2'd0;
   localparam logic [1:0] CH_MONO = 2'd1;
   localparam logic [1:0] CH_ODD  = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   typedef struct {
      logic [15:0] value;
      logic        channel;
      logic        frame_end;
      logic        clipped;
   } pcm_sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_value;
   logic        rsp_channel_index;
   logic        rsp_frame_end;
   logic        rsp_clipped;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   logic [2:0]  cur_format = wsp_pkg::FORMAT_RESET;
   logic [1:0]  cur_channels = wsp_pkg::CHANNELS_RESET;
   logic [63:0] gathered = 64'd0;
   int unsigned held = 0;
   logic        chan = 1'b0;
   pcm_sample_type pcm_due[$];

   int unsigned mismatch_count = 0;
   int unsigned samples_checked = 0;
   int unsigned clipped_seen = 0;
   int unsigned pcm_bytes = 0;
   int unsigned ignored_bytes = 0;
   int unsigned reg_writes = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   wav_sample_to_pcm16_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_value(rsp_sample_value), .rsp_channel_index(rsp_channel_index),
      .rsp_frame_end(rsp_frame_end), .rsp_clipped(rsp_clipped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned sample_width(input logic [2:0] fmt);
      case (fmt)
         wsp_pkg::FMT_U8:                   return 1;
         wsp_pkg::FMT_S16:                  return 2;
         wsp_pkg::FMT_S24:                  return 3;
         wsp_pkg::FMT_S32, wsp_pkg::FMT_F32: return 4;
         default:                           return 8;
      endcase
   endfunction

   // {clip, value}: sig * 32767 / 2^sh truncated, signed and saturated
   function automatic logic [16:0] pcm_scaled(input logic neg, input logic [63:0] sig,
                                              input int unsigned sh);
      logic [63:0] upper, lower, total, mag;
      int unsigned r;
      upper = (sig >> 20) * 64'd32767;
      lower = (sig & 64'hFFFFF) * 64'd32767;
      total = upper + (lower >> 20);
      r = sh - 20;
      mag = (r >= 64) ? 64'd0 : (total >> r);
      if (!neg) begin
         if (mag > 64'd32767) return {1'b1, wsp_pkg::SAT_POS};
         return {1'b0, mag[15:0]};
      end
      if (mag > 64'd32768) return {1'b1, wsp_pkg::SAT_NEG};
      return {1'b0, 16'd0 - mag[15:0]};
   endfunction

   function automatic logic [16:0] pcm_from_float32(input logic [31:0] w);
      logic [7:0]  e;
      logic [63:0] m;
      logic [15:0] sat;
      e = w[30:23];
      m = {41'd0, w[22:0]};
      sat = w[31] ? wsp_pkg::SAT_NEG : wsp_pkg::SAT_POS;
      if (e == wsp_pkg::F32_EXP_MAX) return (m != 0) ? {1'b1, 16'd0} : {1'b1, sat};
      if (e >= 8'd128) return {1'b1, sat};
      if (e == 8'd0) return pcm_scaled(w[31], m, 149);
      return pcm_scaled(w[31], m | 64'h800000, 150 - int'(e));
   endfunction

   function automatic logic [16:0] pcm_from_float64(input logic [63:0] w);
      logic [10:0] e;
      logic [63:0] m;
      logic [15:0] sat;
      e = w[62:52];
      m = {12'd0, w[51:0]};
      sat = w[63] ? wsp_pkg::SAT_NEG : wsp_pkg::SAT_POS;
      if (e == wsp_pkg::F64_EXP_MAX) return (m != 0) ? {1'b1, 16'd0} : {1'b1, sat};
      if (e >= 11'd1024) return {1'b1, sat};
      if (e == 11'd0) return pcm_scaled(w[63], m, 1074);
      return pcm_scaled(w[63], m | (64'd1 << 52), 1075 - int'(e));
   endfunction

   // advance the predicted gatherer by one accepted byte
   task automatic track_byte(input logic [7:0] b);
      logic [16:0]    conv;
      logic           stereo;
      pcm_sample_type due;
      stereo = (cur_channels == wsp_pkg::STEREO_COUNT);
      if (cur_format > wsp_pkg::FMT_F64) begin
         ignored_bytes++;
         return;
      end
      pcm_bytes++;
      gathered = gathered | ({56'd0, b} << (8 * held));
      held++;
      if (held < sample_width(cur_format)) return;
      case (cur_format)
         wsp_pkg::FMT_U8:  conv = {1'b0, gathered[7] ^ 1'b1, gathered[6:0], 8'h00};
         wsp_pkg::FMT_S16: conv = {1'b0, gathered[15:0]};
         wsp_pkg::FMT_S24: conv = {1'b0, gathered[23:8]};
         wsp_pkg::FMT_S32: conv = {1'b0, gathered[31:16]};
         wsp_pkg::FMT_F32: conv = pcm_from_float32(gathered[31:0]);
         default:          conv = pcm_from_float64(gathered);
      endcase
      if (!stereo) chan = 1'b0;
      due.value = conv[15:0];
      due.clipped = conv[16];
      due.channel = chan;
      due.frame_end = !stereo || chan;
      pcm_due.push_back(due);
      gathered = 64'd0;
      held = 0;
      chan = stereo ? ~chan : 1'b0;
   endtask

   // one byte beat; called and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
      burst_left--;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_word(input logic [63:0] w, input int unsigned nbytes);
      for (int i = 0; i < nbytes; i++) send_byte(w[8*i +: 8]);
   endtask

   // hold until every sample has come out and the pipeline has emptied
   task automatic settle();
      while (pcm_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_FORMAT) cur_format = value[2:0];
      else cur_channels = value[1:0];
      gathered = 64'd0;
      held = 0;
      chan = 1'b0;
      reg_writes++;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // upper bits are noise; the register keeps only its own width
   task automatic set_format(input logic [2:0] fmt);
      write_reg(ADDR_FORMAT, {$urandom} & 32'hFFFF_FFF8 | {29'd0, fmt});
   endtask

   task automatic set_channels(input logic [1:0] ch);
      write_reg(ADDR_CHANNELS, {$urandom} & 32'hFFFF_FFFC | {30'd0, ch});
   endtask

   task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = addr;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         flag_mismatch($sformatf("register at %0d reads %h, expected %h", addr, prdata, want));
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   function automatic logic [63:0] random_sample_bits(input logic [2:0] fmt);
      logic [63:0] w;
      int unsigned kind;
      w = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      case (fmt)
         wsp_pkg::FMT_F32: begin
            case (kind)
               6: w[30:23] = 8'd0;
               7: begin
                  w[30:23] = wsp_pkg::F32_EXP_MAX;
                  if ($urandom_range(0, 1)) w[22:0] = 23'd0;
               end
               8: begin
                  w[30:23] = 8'd127;
                  w[22:9] = 14'd0;
               end
               9: ;
               default: w[30:23] = 8'($urandom_range(110, 128));
            endcase
         end
         wsp_pkg::FMT_F64: begin
            case (kind)
               6: w[62:52] = 11'd0;
               7: begin
                  w[62:52] = wsp_pkg::F64_EXP_MAX;
                  if ($urandom_range(0, 1)) w[51:0] = 52'd0;
               end
               8: begin
                  w[62:52] = 11'd1023;
                  w[51:38] = 14'd0;
               end
               9: ;
               default: w[62:52] = 11'($urandom_range(1000, 1024));
            endcase
         end
         default: begin
            if (kind == 0) w = '1;
            else if (kind == 1) w = '0;
         end
      endcase
      return w;
   endfunction

   task automatic test_reset_defaults();
      check_reg(ADDR_FORMAT, {29'd0, wsp_pkg::FORMAT_RESET});
      check_reg(ADDR_CHANNELS, {30'd0, wsp_pkg::CHANNELS_RESET});
      // s16 stereo straight out of reset; odd count leaves a right sample due
      send_word(64'h0000, 2);
      send_word(64'h7FFF, 2);
      send_word(64'h8000, 2);
      send_word(64'hFFFF, 2);
      send_word(64'h0001, 2);
      settle();
   endtask

   task automatic test_integer_formats();
      set_channels(CH_MONO);
      set_format(wsp_pkg::FMT_U8);
      check_reg(ADDR_FORMAT, {29'd0, wsp_pkg::FMT_U8});
      check_reg(ADDR_CHANNELS, {30'd0, CH_MONO});
      send_word(64'h00, 1);
      send_word(64'h80, 1);
      send_word(64'hFF, 1);
      send_word(64'h7F, 1);
      settle();
      set_format(wsp_pkg::FMT_S24);
      send_word(64'h7FFFFF, 3);
      send_word(64'h800000, 3);
      send_word(64'h0000FF, 3);
      send_word(64'hFFFF00, 3);
      settle();
      set_format(wsp_pkg::FMT_S32);
      send_word(64'h7FFFFFFF, 4);
      send_word(64'h80000000, 4);
      send_word(64'h0000FFFF, 4);
      send_word(64'hFFFF0000, 4);
      settle();
   endtask

   task automatic test_float_conversion();
      logic [31:0] f32_cases[14];
      logic [63:0] f64_cases[11];
      // zeros, denormal, unity, just under and just over unity, exact -32768,
      // overflow, infinities and NaNs
      f32_cases = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h3F800000,
                    32'hBF800000, 32'h3F7FFFFF, 32'h3F800101, 32'hBF800101,
                    32'h40000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                    32'h7F800001, 32'h7F7FFFFF};
      f64_cases = '{64'h0000000000000000, 64'h0000000000000001, 64'h3FF0000000000000,
                    64'hBFF0000000000000, 64'h3FEFFFFFFFFFFFFF, 64'h3FF0002000800000,
                    64'hBFF0002000800000, 64'h4000000000000000, 64'h7FF0000000000000,
                    64'hFFF0000000000000, 64'hFFF8000000000000};
      set_channels(wsp_pkg::STEREO_COUNT);
      set_format(wsp_pkg::FMT_F32);
      foreach (f32_cases[i]) send_word({32'd0, f32_cases[i]}, 4);
      settle();
      set_format(wsp_pkg::FMT_F64);
      check_reg(ADDR_FORMAT, {29'd0, wsp_pkg::FMT_F64});
      foreach (f64_cases[i]) send_word(f64_cases[i], 8);
      settle();
   endtask

   task automatic test_channel_modes();
      set_format(wsp_pkg::FMT_S16);
      set_channels(CH_ZERO);
      send_word(64'h1234, 2);
      send_word(64'hFEDC, 2);
      settle();
      set_channels(CH_ODD);
      check_reg(ADDR_CHANNELS, {30'd0, CH_ODD});
      send_word(64'h4321, 2);
      send_word(64'h8001, 2);
      settle();
      // spare format codes swallow bytes
      set_format(FMT_SPARE_LO);
      send_word(64'hA5A5_5A5A_0F0F_F0F0, 8);
      settle();
      set_format(FMT_SPARE_HI);
      check_reg(ADDR_FORMAT, {29'd0, FMT_SPARE_HI});
      send_word(64'hFF00_FF00, 4);
      settle();
      // a write mid-sample drops the partial bytes and restarts at channel 0
      set_format(wsp_pkg::FMT_F32);
      set_channels(wsp_pkg::STEREO_COUNT);
      send_word(64'h3F8000, 3);
      settle();
      set_format(wsp_pkg::FMT_S16);
      send_word(64'h00AB, 1);
      settle();
      set_channels(wsp_pkg::STEREO_COUNT);
      send_word(64'h5555, 2);
      send_word(64'hAAAA, 2);
      send_word(64'h0100, 2);
      settle();
   endtask

   task automatic test_random_stream();
      int unsigned start_bytes, pick, nbytes;
      logic [2:0] fmt;
      logic [1:0] ch;
      start_bytes = pcm_bytes;
      while (pcm_bytes - start_bytes < RANDOM_BYTES) begin
         settle();
         pick = $urandom_range(0, 13);
         fmt = (pick < 12) ? 3'(pick % 6) : ((pick == 12) ? FMT_SPARE_LO : FMT_SPARE_HI);
         ch = ($urandom_range(0, 2) != 0) ? wsp_pkg::STEREO_COUNT
                                          : 2'($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0: set_format(fmt);
            1: set_channels(ch);
            default: begin
               set_format(fmt);
               set_channels(ch);
            end
         endcase
         if (cur_format > wsp_pkg::FMT_F64) begin
            repeat ($urandom_range(3, 16)) send_byte(8'($urandom));
         end else begin
            nbytes = sample_width(cur_format);
            repeat ($urandom_range(4, 40)) send_word(random_sample_bits(cur_format), nbytes);
            // sometimes leave a partial sample for the next write to drop
            if (nbytes > 1 && $urandom_range(0, 3) == 0) begin
               send_word({$urandom, $urandom}, $urandom_range(1, nbytes - 1));
            end
         end
      end
      settle();
   endtask

   // receiver stall pattern, changing character every so often
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall = 1'b0;
         STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
         default:     rsp_stall = (stall_left % 5) != 0;
      endcase
   end

   always @(posedge clock) begin
      pcm_sample_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_checked++;
         if (rsp_clipped === 1'b1) clipped_seen++;
         if (pcm_due.size() == 0) begin
            flag_mismatch($sformatf("sample %h with none expected", rsp_sample_value));
         end else begin
            due = pcm_due.pop_front();
            if (rsp_sample_value !== due.value)
               flag_mismatch($sformatf("sample_value %h, expected %h",
                                       rsp_sample_value, due.value));
            if (rsp_channel_index !== due.channel)
               flag_mismatch($sformatf("channel_index %b, expected %b",
                                       rsp_channel_index, due.channel));
            if (rsp_frame_end !== due.frame_end)
               flag_mismatch($sformatf("frame_end %b, expected %b",
                                       rsp_frame_end, due.frame_end));
            if (rsp_clipped !== due.clipped)
               flag_mismatch($sformatf("clipped %b on %h, expected %b",
                                       rsp_clipped, due.value, due.clipped));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles with %0d samples due", idle_cycles, pcm_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_integer_formats();
      test_float_conversion();
      test_channel_modes();
      test_random_stream();
      repeat (20) @(negedge clock);
      $display("bytes in: %0d converted, %0d ignored; %0d register writes",
               pcm_bytes, ignored_bytes, reg_writes);
      $display("samples checked: %0d, of which %0d clipped", samples_checked, clipped_seen);
      if (mismatch_count == 0 && pcm_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_gather.sv
hw/rtl/wsp_queue.sv
hw/rtl/wsp_convert.sv
hw/rtl/wav_sample_to_pcm16_core.sv
verif/tb_wav_sample_to_pcm16_core.sv
